[rtl/modbus_rtu_register_responder_defines.svh]
// ----------------------------------------------------------------------------
// Modbus RTU register responder assertion macros
// Shared assertion wrappers; they expect clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REGISTER_RESPONDER_DEFINES_SVH
`define MODBUS_RTU_REGISTER_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define MRR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("responder assertion failed");
// Next-cycle implication.
`define MRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("responder assertion failed");
`else
`define MRR_ASSERT_IMPLY(lbl, ante, cons)
`define MRR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/mrr_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus RTU register responder package
// Widths, protocol constants, the reply descriptor and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned CRC_W       = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLAVE_ID = 2'd0,
    CFG_REG_ADDR = 2'd1
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] RESET_SLAVE_ID   = 8'd11;
  localparam logic [ADDR_W-1:0] RESET_REG_ADDR   = 16'd26;
  localparam logic [BYTE_W-1:0] RESET_COUNTER    = 8'd1;

  localparam logic [BYTE_W-1:0] FC_READ_HOLDING      = 8'd3;
  localparam logic [BYTE_W-1:0] EXC_FLAG             = 8'h80;
  localparam logic [BYTE_W-1:0] EXC_ILLEGAL_FUNCTION = 8'd1;
  localparam logic [BYTE_W-1:0] DATA_BYTE_COUNT      = 8'd2;
  localparam logic [BYTE_W-1:0] DATA_HIGH_BYTE       = 8'd0;

  localparam logic [POS_W-1:0] FRAME_LAST    = 3'd7;
  localparam logic [POS_W-1:0] DATA_BODY_LEN = 3'd5;
  localparam logic [POS_W-1:0] EXC_BODY_LEN  = 3'd3;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // One pending reply, as decided by the front end.
  typedef struct packed {
    logic              is_data;
    logic [BYTE_W-1:0] station;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] count;
  } reply_t;

  // Status of the reply queue as seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] din);
    logic [CRC_W-1:0] acc;
    acc = crc ^ {{(CRC_W-BYTE_W){1'b0}}, din};
    for (int b = 0; b < BYTE_W; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

[rtl/mrr_rx_if.sv]
// ----------------------------------------------------------------------------
// Request byte channel
// Valid/ready stream carrying one received request byte.
// ----------------------------------------------------------------------------
interface mrr_rx_if;
  logic                          valid;
  logic                          ready;
  logic [mrr_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/mrr_tx_if.sv]
// ----------------------------------------------------------------------------
// Reply byte channel
// Valid/ready stream carrying one reply byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface mrr_tx_if;
  logic                          valid;
  logic                          ready;
  logic [mrr_pkg::BYTE_W-1:0]    tx_byte;
  logic                          last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

[rtl/mrr_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register writes: register index and write data.
// ----------------------------------------------------------------------------
interface mrr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mrr_pkg::CFG_INDEX_W-1:0]   addr;
  logic [mrr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/modbus_rtu_register_responder.sv]
// Order: the eighth request byte pushes its reply into the queue, and the queue head is then
// registered into the output byte by byte; a data reply has 7 bytes and an exception 5.
// Throughput: one request byte per cycle; the eighth byte of a frame waits only while the
// reply queue is full. Replies leave at one byte per cycle, stalled only by out_tx.ready.
// Reset (synchronous, rst_n low) clears the frame position and the queue, restores
// slave_id 11, register_address 26 and reply counter 1.
// ----------------------------------------------------------------------------
// Modbus RTU register responder
// Answers read-holding-register requests for one register with data or exception.
// ----------------------------------------------------------------------------
module modbus_rtu_register_responder #(
  parameter int unsigned QUEUE_DEPTH = mrr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  mrr_rx_if.sink     in_rx,
  mrr_tx_if.source   out_tx,
  mrr_cfg_if.sink    cfg_wr
);

  logic                  push;
  logic                  pop;
  mrr_pkg::reply_t       push_reply;
  mrr_pkg::reply_t       head_reply;
  mrr_pkg::queue_stat_t  q_stat;

  mrr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx      (in_rx),
    .cfg_wr     (cfg_wr),
    .q_stat     (q_stat),
    .push       (push),
    .push_reply (push_reply)
  );

  mrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_reply (push_reply),
    .pop        (pop),
    .head_reply (head_reply),
    .q_stat     (q_stat)
  );

  mrr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_reply (head_reply),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tx     (out_tx)
  );

endmodule

[rtl/mrr_front.sv]
// ----------------------------------------------------------------------------
// Responder front end
// Tracks the frame position, captures the request head and decides the reply.
// ----------------------------------------------------------------------------
module mrr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  mrr_rx_if.sink                in_rx,
  mrr_cfg_if.sink               cfg_wr,
  input  mrr_pkg::queue_stat_t  q_stat,
  output logic                  push,
  output mrr_pkg::reply_t       push_reply
);

  logic [mrr_pkg::POS_W-1:0]  pos_r;
  logic [mrr_pkg::BYTE_W-1:0] head_r [4];
  logic [mrr_pkg::BYTE_W-1:0] slave_id_r;
  logic [mrr_pkg::ADDR_W-1:0] reg_addr_r;
  logic [mrr_pkg::BYTE_W-1:0] counter_r;

  logic accept;
  logic frame_end;
  logic id_match;
  logic is_data;

  // Only the closing byte of a frame needs room in the queue.
  assign frame_end    = (pos_r == mrr_pkg::FRAME_LAST);
  assign in_rx.ready  = !(frame_end && q_stat.full);
  assign accept       = in_rx.valid && in_rx.ready;
  assign cfg_wr.ready = 1'b1;

  assign id_match = (head_r[0] == slave_id_r);
  assign is_data  = (head_r[1] == mrr_pkg::FC_READ_HOLDING) &&
                    ({head_r[2], head_r[3]} == reg_addr_r);

  assign push               = accept && frame_end && id_match;
  assign push_reply.is_data = is_data;
  assign push_reply.station = head_r[0];
  assign push_reply.code    = is_data ? mrr_pkg::FC_READ_HOLDING
                                      : mrr_pkg::EXC_FLAG + head_r[1];
  assign push_reply.count   = counter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      slave_id_r <= mrr_pkg::RESET_SLAVE_ID;
      reg_addr_r <= mrr_pkg::RESET_REG_ADDR;
      counter_r  <= mrr_pkg::RESET_COUNTER;
    end else begin
      if (accept) begin
        pos_r <= pos_r + 1'b1;
      end
      if (push && is_data) begin
        counter_r <= counter_r + 1'b1;
      end
      if (cfg_wr.valid && cfg_wr.ready) begin
        unique case (cfg_wr.addr)
          mrr_pkg::CFG_SLAVE_ID: slave_id_r <= cfg_wr.data[mrr_pkg::BYTE_W-1:0];
          mrr_pkg::CFG_REG_ADDR: reg_addr_r <= cfg_wr.data[mrr_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Bytes 0 to 3 of each frame are kept; the rest are only counted.
  always_ff @(posedge clk) begin
    if (accept && !pos_r[2]) begin
      head_r[pos_r[1:0]] <= in_rx.rx_byte;
    end
  end

endmodule

[rtl/mrr_queue.sv]
// ----------------------------------------------------------------------------
// Reply queue
// Small FIFO of decided replies between the front and back ends.
// ----------------------------------------------------------------------------
`include "modbus_rtu_register_responder_defines.svh"

module mrr_queue #(
  parameter int unsigned DEPTH = mrr_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mrr_pkg::reply_t       push_reply,
  input  logic                  pop,
  output mrr_pkg::reply_t       head_reply,
  output mrr_pkg::queue_stat_t  q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mrr_pkg::reply_t   slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_reply   = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_reply;
    end
  end

  `MRR_ASSERT_IMPLY(a_no_push_when_full, push, !q_stat.full || pop)
  `MRR_ASSERT_IMPLY(a_no_pop_when_empty, pop, !q_stat.empty)
  `MRR_ASSERT_IMPLY(a_count_bounded, 1'b1, count_r <= CNT_W'(DEPTH))

endmodule

[rtl/mrr_back.sv]
// ----------------------------------------------------------------------------
// Responder back end
// Serializes the reply at the queue head and appends the CRC-16, low byte first.
// ----------------------------------------------------------------------------
`include "modbus_rtu_register_responder_defines.svh"

module mrr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mrr_pkg::reply_t       head_reply,
  input  mrr_pkg::queue_stat_t  q_stat,
  output logic                  pop,
  mrr_tx_if.source              out_tx
);

  logic [mrr_pkg::POS_W-1:0]  idx_r;
  logic [mrr_pkg::CRC_W-1:0]  crc_r;
  logic                       out_valid_r;
  logic [mrr_pkg::BYTE_W-1:0] tx_byte_r;
  logic                       last_r;

  logic [mrr_pkg::POS_W-1:0]  idx_nxt;
  logic [mrr_pkg::CRC_W-1:0]  crc_nxt;
  logic [mrr_pkg::BYTE_W-1:0] tx_byte_nxt;
  logic                       last_nxt;
  logic [mrr_pkg::BYTE_W-1:0] body_byte;
  logic [mrr_pkg::POS_W-1:0]  body_len;
  logic                       step;

  assign out_tx.valid     = out_valid_r;
  assign out_tx.tx_byte   = tx_byte_r;
  assign out_tx.last_byte = last_r;

  // The output register frees up whenever its byte is taken.
  assign step     = (!out_valid_r || out_tx.ready) && !q_stat.empty;
  assign body_len = head_reply.is_data ? mrr_pkg::DATA_BODY_LEN : mrr_pkg::EXC_BODY_LEN;
  assign pop      = step && last_nxt;

  always_comb begin
    unique case (idx_r)
      3'd0:    body_byte = head_reply.station;
      3'd1:    body_byte = head_reply.code;
      3'd2:    body_byte = head_reply.is_data ? mrr_pkg::DATA_BYTE_COUNT
                                              : mrr_pkg::EXC_ILLEGAL_FUNCTION;
      3'd3:    body_byte = mrr_pkg::DATA_HIGH_BYTE;
      3'd4:    body_byte = head_reply.count;
      default: body_byte = '0;
    endcase
  end

  always_comb begin
    priority if (idx_r < body_len) begin
      tx_byte_nxt = body_byte;
      last_nxt    = 1'b0;
      crc_nxt     = mrr_pkg::crc_byte(crc_r, body_byte);
      idx_nxt     = idx_r + 1'b1;
    end else if (idx_r == body_len) begin
      tx_byte_nxt = crc_r[7:0];
      last_nxt    = 1'b0;
      crc_nxt     = crc_r;
      idx_nxt     = idx_r + 1'b1;
    end else begin
      tx_byte_nxt = crc_r[15:8];
      last_nxt    = 1'b1;
      crc_nxt     = mrr_pkg::CRC_INIT;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= mrr_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        idx_r       <= idx_nxt;
        crc_r       <= crc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tx.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tx_byte_r <= tx_byte_nxt;
      last_r    <= last_nxt;
    end
  end

  `MRR_ASSERT_IMPLY(a_idx_in_frame, !q_stat.empty, idx_r <= body_len + 1'b1)
  `MRR_ASSERT_IMPLY(a_idle_clean, q_stat.empty, idx_r == '0 && crc_r == mrr_pkg::CRC_INIT)
  `MRR_ASSERT_NEXT(a_crc_restart, pop, crc_r == mrr_pkg::CRC_INIT && idx_r == '0)

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Modbus RTU register responder testbench
// Sends request frames: a short directed table, then random frames, most of
// them well formed. An internal model of the responder predicts each reply
// byte. Both channels idle at random, and the registers change between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int PHASES        = 6;
  localparam int FRAMES_PER_PHASE = 9;
  localparam int DIRECTED_ROWS = 24;

  // Index values that map to no register; writes to them must change nothing.
  localparam logic [mrr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 2'd2;
  localparam logic [mrr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 2'd3;

  typedef struct packed {
    logic [mrr_pkg::BYTE_W-1:0] tx;
    logic                       last;
  } reply_byte_t;

  // One request byte of the directed table. On rows with typed set, the reply
  // body is given here and only its CRC comes from the model.
  typedef struct packed {
    logic [mrr_pkg::BYTE_W-1:0] rx;
    logic                       typed;
    logic [2:0]                 body_len;
    logic [39:0]                body;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mrr_rx_if  in_rx();
  mrr_tx_if  out_tx();
  mrr_cfg_if cfg_wr();

  modbus_rtu_register_responder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rx  (in_rx),
    .out_tx (out_tx),
    .cfg_wr (cfg_wr)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Model of the responder.
  logic [mrr_pkg::BYTE_W-1:0] station_id;
  logic [mrr_pkg::ADDR_W-1:0] holding_addr;
  logic [mrr_pkg::POS_W-1:0]  frame_pos;
  logic [mrr_pkg::BYTE_W-1:0] head [4];
  logic [mrr_pkg::BYTE_W-1:0] reply_count;

  reply_byte_t reply_q [$];
  reply_byte_t expected_byte;
  stim_row_t   directed_rows [DIRECTED_ROWS];
  logic [mrr_pkg::BYTE_W-1:0] no_body [5];

  int errors;
  int bytes_sent;
  int bytes_checked;
  int data_replies;
  int exception_replies;
  int silent_frames;
  int settings_used;
  int burst_left;
  int unsigned sink_cycle;
  int sink_hold;

  task automatic advance_responder(input logic [mrr_pkg::BYTE_W-1:0] b,
                                   output logic [mrr_pkg::BYTE_W-1:0] body [5],
                                   output int body_len);
    logic [mrr_pkg::POS_W-1:0]  pos;
    logic [mrr_pkg::ADDR_W-1:0] addr;
    pos = frame_pos;
    body_len = 0;
    foreach (body[i]) body[i] = '0;
    if (pos < 4) head[pos[1:0]] = b;
    frame_pos = pos + 1'b1;
    if (pos == mrr_pkg::FRAME_LAST) begin
      if (head[0] != station_id) begin
        silent_frames++;
      end else begin
        addr = {head[2], head[3]};
        body[0] = station_id;
        if (head[1] == mrr_pkg::FC_READ_HOLDING && addr == holding_addr) begin
          body[1] = mrr_pkg::FC_READ_HOLDING;
          body[2] = mrr_pkg::DATA_BYTE_COUNT;
          body[3] = mrr_pkg::DATA_HIGH_BYTE;
          body[4] = reply_count;
          reply_count = reply_count + 1'b1;
          body_len = 5;
          data_replies++;
        end else begin
          body[1] = mrr_pkg::EXC_FLAG + head[1];
          body[2] = mrr_pkg::EXC_ILLEGAL_FUNCTION;
          body_len = 3;
          exception_replies++;
        end
      end
    end
  endtask

  function automatic logic [mrr_pkg::CRC_W-1:0] modbus_crc(
      input logic [mrr_pkg::BYTE_W-1:0] body [5], input int len);
    logic [mrr_pkg::CRC_W-1:0] acc;
    acc = mrr_pkg::CRC_INIT;
    for (int n = 0; n < len; n++) begin
      acc[7:0] = acc[7:0] ^ body[n];
      for (int k = 0; k < 8; k++) begin
        acc = acc[0] ? ((acc >> 1) ^ mrr_pkg::CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  task automatic queue_reply(input logic [mrr_pkg::BYTE_W-1:0] body [5], input int len);
    logic [mrr_pkg::CRC_W-1:0] crc;
    if (len != 0) begin
      crc = modbus_crc(body, len);
      for (int k = 0; k < len; k++) reply_q.push_back(reply_byte_t'{body[k], 1'b0});
      reply_q.push_back(reply_byte_t'{crc[7:0], 1'b0});
      reply_q.push_back(reply_byte_t'{crc[15:8], 1'b1});
    end
  endtask

  // Sends one request byte in bursts with random gaps and predicts its reply.
  task automatic send_byte(input logic [mrr_pkg::BYTE_W-1:0] b, input logic typed,
                           input int typed_len,
                           input logic [mrr_pkg::BYTE_W-1:0] typed_body [5]);
    logic [mrr_pkg::BYTE_W-1:0] body [5];
    int len;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_rx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
    in_rx.valid   <= 1'b1;
    in_rx.rx_byte <= b;
    do @(posedge clk); while (!in_rx.ready);
    bytes_sent++;
    advance_responder(b, body, len);
    if (typed) queue_reply(typed_body, typed_len);
    else queue_reply(body, len);
  endtask

  task automatic send_request_frame();
    logic [mrr_pkg::BYTE_W-1:0] frame [8];
    logic [mrr_pkg::ADDR_W-1:0] addr;
    int pick;
    pick = $urandom_range(0, 99);
    frame[0] = station_id;
    frame[1] = mrr_pkg::FC_READ_HOLDING;
    addr = holding_addr;
    if (pick < 65) begin
      // Well formed request for the configured register.
    end else if (pick < 80) begin
      frame[1] = 8'($urandom_range(0, 255));
      addr = 16'($urandom_range(0, 65535));
    end else if (pick < 88) begin
      addr = holding_addr ^ (16'd1 << $urandom_range(0, 15));
    end else if (pick < 95) begin
      frame[0] = station_id ^ 8'($urandom_range(1, 255));
    end else begin
      frame[0] = 8'($urandom_range(0, 255));
      frame[1] = 8'($urandom_range(0, 255));
      addr = 16'($urandom_range(0, 65535));
    end
    frame[2] = addr[15:8];
    frame[3] = addr[7:0];
    for (int i = 4; i < 8; i++) frame[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 8; i++) send_byte(frame[i], 1'b0, 0, no_body);
  endtask

  task automatic write_register(input logic [mrr_pkg::CFG_INDEX_W-1:0] index,
                                input logic [mrr_pkg::CFG_DATA_W-1:0] value);
    cfg_wr.valid <= 1'b1;
    cfg_wr.addr  <= index;
    cfg_wr.data  <= value;
    do @(posedge clk); while (!cfg_wr.ready);
    if (index == mrr_pkg::CFG_SLAVE_ID) station_id = value[mrr_pkg::BYTE_W-1:0];
    else if (index == mrr_pkg::CFG_REG_ADDR) holding_addr = value;
  endtask

  // Stops the sender and waits until every reply is out and the block is idle.
  task automatic quiesce();
    in_rx.valid <= 1'b0;
    burst_left = 0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The reply side cycles through always ready, coin flips, a fixed pattern
  // and long stalls.
  always @(posedge clk) begin
    sink_cycle = sink_cycle + 1;
    case ((sink_cycle / 96) % 4)
      0: begin
        out_tx.ready <= 1'b1;
      end
      1: begin
        out_tx.ready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_tx.ready <= (sink_cycle % 3 != 0);
      end
      default: begin
        if (sink_hold > 0) begin
          sink_hold--;
          out_tx.ready <= 1'b0;
        end else begin
          out_tx.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) sink_hold = $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tx.valid && out_tx.ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: reply byte %02h (last %0b) with no request pending",
                 $time, out_tx.tx_byte, out_tx.last_byte);
        errors++;
      end else begin
        expected_byte = reply_q.pop_front();
        if (out_tx.tx_byte !== expected_byte.tx) begin
          $display("%0t: tx_byte expected %02h, got %02h",
                   $time, expected_byte.tx, out_tx.tx_byte);
          errors++;
        end
        if (out_tx.last_byte !== expected_byte.last) begin
          $display("%0t: last_byte expected %0b, got %0b",
                   $time, expected_byte.last, out_tx.last_byte);
          errors++;
        end
        bytes_checked++;
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    logic [mrr_pkg::BYTE_W-1:0] typed_body [5];
    logic [mrr_pkg::ADDR_W-1:0] late_addr;
    rst_n = 1'b0;
    in_rx.valid = 1'b0;
    in_rx.rx_byte = '0;
    out_tx.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.addr = '0;
    cfg_wr.data = '0;
    foreach (no_body[i]) no_body[i] = '0;
    errors = 0;
    bytes_sent = 0;
    bytes_checked = 0;
    data_replies = 0;
    exception_replies = 0;
    silent_frames = 0;
    settings_used = 1;
    burst_left = 0;
    sink_cycle = 0;
    sink_hold = 0;
    station_id = mrr_pkg::RESET_SLAVE_ID;
    holding_addr = mrr_pkg::RESET_REG_ADDR;
    frame_pos = '0;
    foreach (head[i]) head[i] = '0;
    reply_count = mrr_pkg::RESET_COUNTER;

    directed_rows = '{
      // Data request at the reset settings; the counter starts at one.
      '{8'h0B, 1'b0, 3'd0, 40'h0}, '{8'h03, 1'b0, 3'd0, 40'h0},
      '{8'h00, 1'b0, 3'd0, 40'h0}, '{8'h1A, 1'b0, 3'd0, 40'h0},
      '{8'h00, 1'b0, 3'd0, 40'h0}, '{8'h00, 1'b0, 3'd0, 40'h0},
      '{8'h00, 1'b0, 3'd0, 40'h0}, '{8'h00, 1'b1, 3'd5, 40'h0B_03_02_00_01},
      // Function code 0xFF wraps to exception code 0x7F; the trailing
      // bytes at their maximum are not stored.
      '{8'h0B, 1'b0, 3'd0, 40'h0}, '{8'hFF, 1'b0, 3'd0, 40'h0},
      '{8'hFF, 1'b0, 3'd0, 40'h0}, '{8'hFF, 1'b0, 3'd0, 40'h0},
      '{8'hFF, 1'b0, 3'd0, 40'h0}, '{8'hFF, 1'b0, 3'd0, 40'h0},
      '{8'hFF, 1'b0, 3'd0, 40'h0}, '{8'hFF, 1'b1, 3'd3, 40'h0B_7F_01_00_00},
      // Another station: no reply at all.
      '{8'h00, 1'b0, 3'd0, 40'h0}, '{8'h03, 1'b0, 3'd0, 40'h0},
      '{8'h00, 1'b0, 3'd0, 40'h0}, '{8'h1A, 1'b0, 3'd0, 40'h0},
      '{8'h00, 1'b0, 3'd0, 40'h0}, '{8'h00, 1'b0, 3'd0, 40'h0},
      '{8'h00, 1'b0, 3'd0, 40'h0}, '{8'h00, 1'b1, 3'd0, 40'h0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      for (int k = 0; k < 5; k++) typed_body[k] = directed_rows[i].body[39 - 8 * k -: 8];
      send_byte(directed_rows[i].rx, directed_rows[i].typed,
                directed_rows[i].body_len, typed_body);
    end

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      case (p)
        0: begin
          write_register(mrr_pkg::CFG_SLAVE_ID, 16'h0000);
          write_register(mrr_pkg::CFG_REG_ADDR, 16'h0000);
        end
        1: begin
          // Upper data bits are not part of the station id.
          write_register(mrr_pkg::CFG_SLAVE_ID, 16'hFFFF);
          write_register(mrr_pkg::CFG_REG_ADDR, 16'hFFFF);
        end
        default: begin
          write_register(mrr_pkg::CFG_SLAVE_ID, 16'($urandom_range(0, 65535)));
          write_register(CFG_SPARE_LOW, 16'($urandom_range(0, 65535)));
          write_register(mrr_pkg::CFG_REG_ADDR, 16'($urandom_range(0, 65535)));
          write_register(CFG_SPARE_HIGH, 16'($urandom_range(0, 65535)));
        end
      endcase
      cfg_wr.valid <= 1'b0;
      settings_used++;
      for (int f = 0; f < FRAMES_PER_PHASE; f++) send_request_frame();

      if (p == 1) begin
        // Change the register address halfway through a frame: the decision
        // at the eighth byte must use the new value.
        late_addr = 16'($urandom_range(0, 65535));
        send_byte(station_id, 1'b0, 0, no_body);
        send_byte(mrr_pkg::FC_READ_HOLDING, 1'b0, 0, no_body);
        send_byte(late_addr[15:8], 1'b0, 0, no_body);
        send_byte(late_addr[7:0], 1'b0, 0, no_body);
        quiesce();
        write_register(mrr_pkg::CFG_REG_ADDR, late_addr);
        cfg_wr.valid <= 1'b0;
        settings_used++;
        for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, 0, no_body);
      end
    end

    in_rx.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reply_q.size() != 0) begin
      $display("%0t: %0d reply bytes never arrived", $time, reply_q.size());
      errors += reply_q.size();
    end

    $display("%0d request bytes sent: %0d data replies, %0d exceptions, %0d frames not ours",
             bytes_sent, data_replies, exception_replies, silent_frames);
    $display("%0d reply bytes checked over %0d register settings",
             bytes_checked, settings_used);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
